// File: hw/rtl/tbac_pkg.sv
// ============================================================================
// tbac_pkg
// Shared types and constants of the thumb branch address converter: opcode
// prefixes, the record that travels from the front part to the back part,
// and the sizing of the queue between them.
// ============================================================================
package tbac_pkg;

    // field widths
    localparam int HW_W          = 16;
    localparam int FIELD_W       = 11;
    localparam int POSITION_BITS = 22;

    // halfword prefixes (top five bits)
    localparam logic [HW_W-1:0] PREFIX_MASK = 16'hf800;
    localparam logic [HW_W-1:0] PREFIX_HI   = 16'hf000;
    localparam logic [HW_W-1:0] PREFIX_BL   = 16'hf800;
    localparam logic [HW_W-1:0] PREFIX_BLX  = 16'he800;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // what the back part has to emit for one record
    typedef enum logic [1:0] {
        REC_ONE,   // one beat: first_hw
        REC_TWO,   // two beats: first_hw, then second_hw, both unchanged
        REC_PAIR   // two beats: converted BL/BLX pair
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t                kind;
        logic [HW_W-1:0]          first_hw;
        logic [HW_W-1:0]          second_hw;
        logic [POSITION_BITS-1:0] pos;      // position of second halfword of a pair
        logic                     last;     // stream ends with this record
    } rec_t;

endpackage

// File: hw/rtl/tbac_front.sv
// ============================================================================
// tbac_front
// Accepts halfwords, tracks the stream position and block slot, holds back a
// pair candidate and classifies each step into a record for the back part.
// ============================================================================
module tbac_front import tbac_pkg::*; #(
    parameter int BLOCK_HALFWORDS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [HW_W-1:0] halfword_in,
    input  logic            last_in,
    input  logic            queue_full,
    output logic            push,
    output rec_t            rec
);

    localparam int SLOT_W = (BLOCK_HALFWORDS > 1) ? $clog2(BLOCK_HALFWORDS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCK_HALFWORDS - 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                     held_valid_reg, held_valid_next;
    logic [HW_W-1:0]          held_hw_reg, held_hw_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;

    logic            accept;
    logic [HW_W-1:0] prefix;
    logic            is_link;
    logic            is_hi;
    logic            hold_now;

    // handshake
    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    // classify the incoming halfword
    assign prefix   = halfword_in & PREFIX_MASK;
    assign is_link  = (prefix == PREFIX_BL) || (prefix == PREFIX_BLX);
    assign is_hi    = (prefix == PREFIX_HI);
    assign hold_now = ~last_in & (slot_reg != LAST_SLOT) & is_hi;

    // build the record
    always_comb
    begin
        rec.kind      = REC_ONE;
        rec.first_hw  = halfword_in;
        rec.second_hw = halfword_in;
        rec.pos       = pos_reg;
        rec.last      = last_in;
        if (held_valid_reg)
        begin
            rec.first_hw = held_hw_reg;
            if (is_link)
            begin
                rec.kind = REC_PAIR;
            end
            else if (hold_now)
            begin
                rec.kind = REC_ONE;
                rec.last = 1'b0;
            end
            else
            begin
                rec.kind = REC_TWO;
            end
        end
        push = accept & (held_valid_reg | ~hold_now);
    end

    // next state
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_hw_next    = held_hw_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        if (accept)
        begin
            held_valid_next = hold_now & ~(held_valid_reg & is_link);
            held_hw_next    = hold_now ? halfword_in : '0;
            if (last_in)
            begin
                pos_next  = '0;
                slot_next = '0;
            end
            else
            begin
                pos_next  = pos_reg + 1'b1;
                // slot follows pos mod block size, also across the position wrap
                if ((slot_reg == LAST_SLOT) || (pos_reg == POS_MAX))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_hw_reg    <= '0;
            pos_reg        <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_hw_reg    <= held_hw_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
        end
    end

endmodule

// File: hw/rtl/tbac_queue.sv
// ============================================================================
// tbac_queue
// Short record queue between the front and back parts, so that each side
// can stall on its own.
// ============================================================================
module tbac_queue import tbac_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output rec_t head_rec
);

    rec_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    // status
    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    assign do_push = push & ~full;
    assign do_pop  = pop & head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: hw/rtl/tbac_back.sv
// ============================================================================
// tbac_back
// Takes records from the queue, applies the branch offset conversion and
// emits, unless stalled, one output beat per cycle through an output register.
// ============================================================================
module tbac_back import tbac_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  rec_t            head_rec,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [HW_W-1:0] halfword_out,
    output logic            converted,
    output logic            last_out
);

    localparam int V_W = 2 * FIELD_W;

    logic            out_valid_reg;
    logic            sel_reg, sel_next;
    logic [HW_W-1:0] hw_reg;
    logic            conv_reg;
    logic            last_reg;

    logic            load;
    logic [V_W-1:0]  target;
    logic [HW_W-1:0] beat_hw;
    logic            beat_conv;
    logic            beat_last;
    logic            beat_final;

    // output register frees up when empty or taken
    assign load = ~out_valid_reg | ~out_stall;

    // converted offset: hi11:lo11 plus position of the second halfword
    assign target = {head_rec.first_hw[FIELD_W-1:0], head_rec.second_hw[FIELD_W-1:0]}
                  + V_W'(head_rec.pos);

    // select the beat for the current sub-step of the record
    always_comb
    begin
        beat_hw    = head_rec.first_hw;
        beat_conv  = 1'b0;
        beat_last  = 1'b0;
        beat_final = 1'b1;
        case (head_rec.kind)
            REC_ONE:
            begin
                beat_last = head_rec.last;
            end
            REC_TWO:
            begin
                beat_final = sel_reg;
                if (sel_reg)
                begin
                    beat_hw   = head_rec.second_hw;
                    beat_last = head_rec.last;
                end
            end
            REC_PAIR:
            begin
                beat_conv  = 1'b1;
                beat_final = sel_reg;
                if (sel_reg)
                begin
                    beat_hw   = (head_rec.second_hw & PREFIX_MASK)
                              | HW_W'(target[FIELD_W-1:0]);
                    beat_last = head_rec.last;
                end
                else
                begin
                    beat_hw = PREFIX_HI | HW_W'(target[V_W-1:FIELD_W]);
                end
            end
            default:
            begin
                beat_last = head_rec.last;
            end
        endcase
    end

    assign pop = head_valid & load & beat_final;

    always_comb
    begin
        sel_next = sel_reg;
        if (head_valid && load)
        begin
            sel_next = ~beat_final;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (load)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            hw_reg   <= beat_hw;
            conv_reg <= beat_conv;
            last_reg <= beat_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign halfword_out = hw_reg;
    assign converted    = conv_reg;
    assign last_out     = last_reg;

endmodule

// File: hw/rtl/thumb_branch_address_converter.sv
// ============================================================================
// thumb_branch_address_converter
// Streaming Thumb BL/BLX address converter over 16-bit halfwords.
// ============================================================================
// Accepts one halfword per cycle unless the record queue is full, emits one
// per cycle on average unless the output stalls; every input halfword leaves
// exactly once, in stream order. A pair candidate (prefix 11110) not marked
// last and not in the block's last slot produces no beat when it arrives; it
// leaves once the next halfword is accepted, followed by that halfword unless
// that one is held back in turn. Records wait in a four-entry queue; the front
// stalls only when it is full, and each beat then passes the output register.
// Position counter and block slot return to zero after a halfword marked last.
module thumb_branch_address_converter import tbac_pkg::*; #(
    parameter int BLOCK_HALFWORDS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [HW_W-1:0] halfword_in,
    input  logic            last_in,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [HW_W-1:0] halfword_out,
    output logic            converted,
    output logic            last_out
);

    logic push;
    rec_t push_rec;
    logic queue_full;
    logic pop;
    logic head_valid;
    rec_t head_rec;

    // front: accept and classify
    tbac_front #(
        .BLOCK_HALFWORDS (BLOCK_HALFWORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .halfword_in (halfword_in),
        .last_in     (last_in),
        .queue_full  (queue_full),
        .push        (push),
        .rec         (push_rec)
    );

    // record queue
    tbac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // back: convert and emit
    tbac_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .halfword_out (halfword_out),
        .converted    (converted),
        .last_out     (last_out)
    );

endmodule
